### rtl/ipg_pkg.sv
// Shared constants, mode codes and helpers for the indicator pattern generator.
// No dependencies; used by every module under rtl.
`default_nettype none
package ipg_pkg;

  localparam int unsigned BEEP_W = 12;
  localparam int unsigned BAT_W  = 11;
  localparam int unsigned EXT_W  = 10;

  localparam int unsigned BUZ_MODE_W = 3;
  localparam int unsigned BAT_MODE_W = 4;
  localparam int unsigned EXT_MODE_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned OUT_W      = 12;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL = 2'd2;

  // buzzer modes
  localparam logic [BUZ_MODE_W-1:0] BUZ_OFF    = 3'd0;
  localparam logic [BUZ_MODE_W-1:0] BUZ_SLOW   = 3'd1;
  localparam logic [BUZ_MODE_W-1:0] BUZ_FAST   = 3'd2;
  localparam logic [BUZ_MODE_W-1:0] BUZ_VFAST  = 3'd3;
  localparam logic [BUZ_MODE_W-1:0] BUZ_STEADY = 3'd4;
  localparam logic [BUZ_MODE_W-1:0] BUZ_SOS    = 3'd5;

  // battery LED modes
  localparam logic [BAT_MODE_W-1:0] BAT_OFF      = 4'd0;
  localparam logic [BAT_MODE_W-1:0] BAT_BLINK    = 4'd1;
  localparam logic [BAT_MODE_W-1:0] BAT_FILL2    = 4'd2;
  localparam logic [BAT_MODE_W-1:0] BAT_FILL3    = 4'd3;
  localparam logic [BAT_MODE_W-1:0] BAT_SOLID1   = 4'd4;
  localparam logic [BAT_MODE_W-1:0] BAT_SOLID2   = 4'd5;
  localparam logic [BAT_MODE_W-1:0] BAT_SOLID3   = 4'd6;
  localparam logic [BAT_MODE_W-1:0] BAT_SHORT    = 4'd7;
  localparam logic [BAT_MODE_W-1:0] BAT_NOBAT    = 4'd8;
  localparam logic [BAT_MODE_W-1:0] BAT_CAL_RUN  = 4'd9;
  localparam logic [BAT_MODE_W-1:0] BAT_CAL_FAIL = 4'd10;

  // external LED modes
  localparam logic [EXT_MODE_W-1:0] EXT_OFF   = 2'd0;
  localparam logic [EXT_MODE_W-1:0] EXT_ON    = 2'd1;
  localparam logic [EXT_MODE_W-1:0] EXT_BLINK = 2'd2;

  // beep timing
  localparam logic [BEEP_W-1:0] SLOW_ON   = 12'd1950;
  localparam logic [BEEP_W-1:0] SLOW_END  = 12'd2000;
  localparam logic [BEEP_W-1:0] FAST_ON   = 12'd450;
  localparam logic [BEEP_W-1:0] FAST_END  = 12'd500;
  localparam logic [BEEP_W-1:0] VFAST_ON  = 12'd100;
  localparam logic [BEEP_W-1:0] VFAST_END = 12'd150;
  localparam logic [BEEP_W-1:0] SOS_END   = 12'd4000;

  localparam int unsigned SOS_N = 18;
  typedef logic [BEEP_W-1:0] sos_tab_t [SOS_N];
  localparam sos_tab_t SOS_AT = '{
    12'd1, 12'd100, 12'd200, 12'd300, 12'd400, 12'd500, 12'd700, 12'd900, 12'd1000,
    12'd1200, 12'd1300, 12'd1500, 12'd1700, 12'd1800, 12'd1900, 12'd2000, 12'd2100,
    12'd2200
  };

  // SOS edge lookup: hit set when count lands on an edge, level is tone on/off there
  typedef struct packed {
    logic hit;
    logic level;
  } sos_edge_t;

  function automatic sos_edge_t sos_lookup(input logic [BEEP_W-1:0] c);
    sos_edge_t r;
    r.hit   = 1'b0;
    r.level = 1'b0;
    for (int i = 0; i < SOS_N; i++) begin
      if (c == SOS_AT[i]) begin
        r.hit   = 1'b1;
        r.level = ~i[0];
      end
    end
    return r;
  endfunction

  // strictly between lo and hi
  function automatic logic between(input logic [BAT_W-1:0] c, input logic [BAT_W-1:0] lo,
                                   input logic [BAT_W-1:0] hi);
    return (c > lo) && (c < hi);
  endfunction

endpackage
`default_nettype wire

### rtl/indicator_pattern_generator_unit.sv
// Indicator pattern generator, top level: mode registers, pattern units, result register.
// Depends on ipg_pkg, ipg_buzzer, ipg_battery, ipg_external.
//
// Takes one item per clock. Each item carries a tick bit; a tick of 1 advances the
// buzzer, battery/voltage LED and external LED patterns by one millisecond, a tick of 0
// leaves them alone. Every item yields one result with all current levels, ready in the
// result register the cycle after the item is taken. The input is taken whenever the
// result register is empty or being drained, so a stalled output holds the input off.
// Mode registers are written through the cfg port, which is always ready; index 3 is
// ignored. Patterns go on from their counters' current values across mode changes.
`default_nettype none
module indicator_pattern_generator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [ipg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] tick
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] buzzer_on, [3:1] battery_leds, [10:4] voltage_leds, [11] external_led
  output logic [ipg_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ipg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ipg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [ipg_pkg::BUZ_MODE_W-1:0] buzzer_mode;
  logic [ipg_pkg::BAT_MODE_W-1:0] battery_led_mode;
  logic [ipg_pkg::EXT_MODE_W-1:0] external_led_mode;

  logic                      out_valid;
  logic [ipg_pkg::OUT_W-1:0] out_data;
  logic                      accept, step;
  logic                      buz_next, ext_next;
  logic [2:0]                leds_next;
  logic [6:0]                volt_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign step          = accept & s_axis_tdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      buzzer_mode       <= ipg_pkg::BUZ_OFF;
      battery_led_mode  <= ipg_pkg::BAT_OFF;
      external_led_mode <= ipg_pkg::EXT_OFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        ipg_pkg::CFG_BUZZER:   buzzer_mode       <= cfg_data[ipg_pkg::BUZ_MODE_W-1:0];
        ipg_pkg::CFG_BATTERY:  battery_led_mode  <= cfg_data;
        ipg_pkg::CFG_EXTERNAL: external_led_mode <= cfg_data[ipg_pkg::EXT_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  ipg_buzzer u_buzzer (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .mode       (buzzer_mode),
    .level_next (buz_next)
  );

  ipg_battery u_battery (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .mode      (battery_led_mode),
    .leds_next (leds_next),
    .volt_next (volt_next)
  );

  ipg_external u_external (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .mode       (external_led_mode),
    .level_next (ext_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {ext_next, volt_next, leds_next, buz_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(ipg_pkg::OUT_TDATA_W - ipg_pkg::OUT_W){1'b0}}, out_data};

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item produced no result");

endmodule
`default_nettype wire

### rtl/ipg_buzzer.sv
// Buzzer pattern: shared beep counter and held tone level.
// Depends on ipg_pkg.
`default_nettype none
module ipg_buzzer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [ipg_pkg::BUZ_MODE_W-1:0]  mode,
  output logic                                 level_next
);

  logic [ipg_pkg::BEEP_W-1:0] beep_count, beep_count_next, inc;
  logic                       level;
  ipg_pkg::sos_edge_t         sos;

  assign inc = beep_count + 1'b1;
  assign sos = ipg_pkg::sos_lookup(inc);

  always_comb begin
    level_next      = level;
    beep_count_next = beep_count;
    if (step) begin
      case (mode)
        ipg_pkg::BUZ_OFF:    level_next = 1'b0;
        ipg_pkg::BUZ_STEADY: level_next = 1'b1;
        ipg_pkg::BUZ_SLOW: begin
          beep_count_next = inc;
          if (inc == ipg_pkg::SLOW_ON) level_next = 1'b1;
          if (inc > ipg_pkg::SLOW_END) begin
            level_next = 1'b0;
            beep_count_next = '0;
          end
        end
        ipg_pkg::BUZ_FAST: begin
          beep_count_next = inc;
          if (inc == ipg_pkg::FAST_ON) level_next = 1'b1;
          if (inc > ipg_pkg::FAST_END) begin
            level_next = 1'b0;
            beep_count_next = '0;
          end
        end
        ipg_pkg::BUZ_VFAST: begin
          beep_count_next = inc;
          if (inc == ipg_pkg::VFAST_ON) level_next = 1'b1;
          if (inc > ipg_pkg::VFAST_END) begin
            level_next = 1'b0;
            beep_count_next = '0;
          end
        end
        ipg_pkg::BUZ_SOS: begin
          beep_count_next = inc;
          if (sos.hit) level_next = sos.level;
          if (inc > ipg_pkg::SOS_END) begin
            level_next = 1'b0;
            beep_count_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beep_count <= '0;
      level      <= 1'b0;
    end else begin
      beep_count <= beep_count_next;
      level      <= level_next;
    end
  end

  a_beep_bound: assert property (@(posedge clk) disable iff (rst)
    beep_count <= ipg_pkg::SOS_END)
    else $error("beep counter past SOS period");

endmodule
`default_nettype wire

### rtl/ipg_battery.sv
// Battery and voltage LED patterns with their shared tick counter.
// Depends on ipg_pkg.
`default_nettype none
module ipg_battery (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [ipg_pkg::BAT_MODE_W-1:0]  mode,
  output logic [2:0]                           leds_next,
  output logic [6:0]                           volt_next
);

  logic [ipg_pkg::BAT_W-1:0] battery_count, battery_count_next, c;
  logic [2:0]                battery_level;
  logic [6:0]                voltage_level;

  assign c = battery_count + 1'b1;

  always_comb begin
    leds_next          = battery_level;
    volt_next          = voltage_level;
    battery_count_next = battery_count;
    if (step) begin
      case (mode)
        ipg_pkg::BAT_OFF: begin
          leds_next          = 3'd0;
          battery_count_next = '0;
        end
        ipg_pkg::BAT_SOLID1: leds_next = 3'd1;
        ipg_pkg::BAT_SOLID2: leds_next = 3'd3;
        ipg_pkg::BAT_SOLID3: leds_next = 3'd7;
        ipg_pkg::BAT_BLINK: begin
          battery_count_next = c;
          leds_next = (c < 11'd500) ? 3'd0 : 3'd1;
          if (c > 11'd1000) battery_count_next = '0;
        end
        ipg_pkg::BAT_FILL2, ipg_pkg::BAT_FILL3: begin
          battery_count_next = c;
          if (c < 11'd500) leds_next = 3'd0;
          if (ipg_pkg::between(c, 11'd500, 11'd1000)) leds_next = 3'd1;
          if (ipg_pkg::between(c, 11'd1000, 11'd1500)) leds_next = 3'd3;
          if (mode == ipg_pkg::BAT_FILL2) begin
            if (c > 11'd1500) battery_count_next = '0;
          end else begin
            if (ipg_pkg::between(c, 11'd1500, 11'd2000)) leds_next = 3'd7;
            if (c > 11'd2000) battery_count_next = '0;
          end
        end
        ipg_pkg::BAT_SHORT: begin
          battery_count_next = c;
          leds_next = (c < 11'd50) ? 3'd7 : 3'd0;
          if (c > 11'd1000) battery_count_next = '0;
        end
        ipg_pkg::BAT_NOBAT: begin
          battery_count_next = c;
          if (c < 11'd50) leds_next = 3'd7;
          if (ipg_pkg::between(c, 11'd50, 11'd150)) leds_next = 3'd0;
          if (ipg_pkg::between(c, 11'd150, 11'd200)) leds_next = 3'd7;
          if (ipg_pkg::between(c, 11'd200, 11'd1000)) leds_next = 3'd0;
          if (c > 11'd1000) battery_count_next = '0;
        end
        ipg_pkg::BAT_CAL_RUN: begin
          battery_count_next = c;
          if (ipg_pkg::between(c, 11'd0, 11'd50))    volt_next = 7'h20;
          if (ipg_pkg::between(c, 11'd50, 11'd100))  volt_next = 7'h10;
          if (ipg_pkg::between(c, 11'd100, 11'd150)) volt_next = 7'h08;
          if (ipg_pkg::between(c, 11'd150, 11'd200)) volt_next = 7'h04;
          if (ipg_pkg::between(c, 11'd200, 11'd250)) volt_next = 7'h02;
          if (ipg_pkg::between(c, 11'd250, 11'd300)) volt_next = 7'h01;
          if (ipg_pkg::between(c, 11'd300, 11'd350)) volt_next = 7'h40;
          if (c > 11'd400) battery_count_next = '0;
        end
        ipg_pkg::BAT_CAL_FAIL: begin
          battery_count_next = c;
          if (ipg_pkg::between(c, 11'd0, 11'd50))   volt_next = 7'h7F;
          if (ipg_pkg::between(c, 11'd50, 11'd1000)) volt_next = 7'h00;
          if (c > 11'd1000) battery_count_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_count <= '0;
      battery_level <= '0;
      voltage_level <= '0;
    end else begin
      battery_count <= battery_count_next;
      battery_level <= leds_next;
      voltage_level <= volt_next;
    end
  end

  a_bat_bound: assert property (@(posedge clk) disable iff (rst)
    battery_count <= 11'd2000)
    else $error("battery counter past longest period");

endmodule
`default_nettype wire

### rtl/ipg_external.sv
// External LED pattern: off, on or blink with its own tick counter.
// Depends on ipg_pkg.
`default_nettype none
module ipg_external (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [ipg_pkg::EXT_MODE_W-1:0]  mode,
  output logic                                 level_next
);

  logic [ipg_pkg::EXT_W-1:0] external_count, external_count_next, inc;
  logic                      level;

  assign inc = external_count + 1'b1;

  always_comb begin
    level_next          = level;
    external_count_next = external_count;
    if (step) begin
      case (mode)
        ipg_pkg::EXT_OFF: begin
          level_next          = 1'b0;
          external_count_next = '0;
        end
        ipg_pkg::EXT_ON: begin
          level_next          = 1'b1;
          external_count_next = '0;
        end
        ipg_pkg::EXT_BLINK: begin
          level_next          = (inc >= 10'd500);
          external_count_next = (inc > 10'd1000) ? '0 : inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      external_count <= '0;
      level          <= 1'b0;
    end else begin
      external_count <= external_count_next;
      level          <= level_next;
    end
  end

  a_ext_bound: assert property (@(posedge clk) disable iff (rst)
    external_count <= 10'd1000)
    else $error("external counter past blink period");

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for indicator_pattern_generator_unit: random tick items and mode phases,
// with every result checked against an in-bench pattern predictor.
// Depends on ipg_pkg and the RTL under rtl.
`timescale 1ns / 1ps
module tb;
  import ipg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic       ext;
    logic [6:0] volt;
    logic [2:0] bat;
    logic       buz;
  } levels_t;

  class pattern_scoreboard;
    logic [BUZ_MODE_W-1:0] buz_mode;
    logic [BAT_MODE_W-1:0] bat_mode;
    logic [EXT_MODE_W-1:0] ext_mode;
    logic [BEEP_W-1:0]     beep_cnt;
    logic [BAT_W-1:0]      bat_cnt;
    logic [EXT_W-1:0]      ext_cnt;
    logic                  buz_lvl;
    logic [2:0]            bat_lvl;
    logic [6:0]            volt_lvl;
    logic                  ext_lvl;
    levels_t               expected_levels[$];
    int                    errors;

    function new();
      buz_mode = BUZ_OFF;
      bat_mode = BAT_OFF;
      ext_mode = EXT_OFF;
      beep_cnt = '0;
      bat_cnt  = '0;
      ext_cnt  = '0;
      buz_lvl  = 1'b0;
      bat_lvl  = '0;
      volt_lvl = '0;
      ext_lvl  = 1'b0;
      errors   = 0;
    endfunction

    function void set_mode(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_BUZZER:   buz_mode = d[BUZ_MODE_W-1:0];
        CFG_BATTERY:  bat_mode = d[BAT_MODE_W-1:0];
        CFG_EXTERNAL: ext_mode = d[EXT_MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function bit strictly_in(input int unsigned c, input int unsigned lo, input int unsigned hi);
      return (c > lo) && (c < hi);
    endfunction

    function void beep_step(input int unsigned on_at, input int unsigned end_at);
      beep_cnt = beep_cnt + 1'b1;
      if (beep_cnt == on_at) buz_lvl = 1'b1;
      if (beep_cnt > end_at) begin
        buz_lvl  = 1'b0;
        beep_cnt = '0;
      end
    endfunction

    function void advance_patterns();
      int unsigned c;
      case (buz_mode)
        BUZ_OFF:    buz_lvl = 1'b0;
        BUZ_SLOW:   beep_step(1950, 2000);
        BUZ_FAST:   beep_step(450, 500);
        BUZ_VFAST:  beep_step(100, 150);
        BUZ_STEADY: buz_lvl = 1'b1;
        BUZ_SOS: begin
          beep_cnt = beep_cnt + 1'b1;
          case (beep_cnt)
            12'd1, 12'd200, 12'd400, 12'd700, 12'd1000, 12'd1300, 12'd1700, 12'd1900,
            12'd2100: buz_lvl = 1'b1;
            12'd100, 12'd300, 12'd500, 12'd900, 12'd1200, 12'd1500, 12'd1800, 12'd2000,
            12'd2200: buz_lvl = 1'b0;
            default: ;
          endcase
          if (beep_cnt > 4000) begin
            buz_lvl  = 1'b0;
            beep_cnt = '0;
          end
        end
        default: ;
      endcase

      case (bat_mode)
        BAT_OFF: begin
          bat_lvl = 3'b000;
          bat_cnt = '0;
        end
        BAT_SOLID1: bat_lvl = 3'b001;
        BAT_SOLID2: bat_lvl = 3'b011;
        BAT_SOLID3: bat_lvl = 3'b111;
        BAT_BLINK, BAT_FILL2, BAT_FILL3, BAT_SHORT, BAT_NOBAT, BAT_CAL_RUN,
        BAT_CAL_FAIL: begin
          bat_cnt = bat_cnt + 1'b1;
          c = bat_cnt;
          case (bat_mode)
            BAT_BLINK: begin
              bat_lvl = (c < 500) ? 3'b000 : 3'b001;
              if (c > 1000) bat_cnt = '0;
            end
            BAT_FILL2, BAT_FILL3: begin
              if (c < 500) bat_lvl = 3'b000;
              if (strictly_in(c, 500, 1000)) bat_lvl = 3'b001;
              if (strictly_in(c, 1000, 1500)) bat_lvl = 3'b011;
              if (bat_mode == BAT_FILL2) begin
                if (c > 1500) bat_cnt = '0;
              end else begin
                if (strictly_in(c, 1500, 2000)) bat_lvl = 3'b111;
                if (c > 2000) bat_cnt = '0;
              end
            end
            BAT_SHORT: begin
              bat_lvl = (c < 50) ? 3'b111 : 3'b000;
              if (c > 1000) bat_cnt = '0;
            end
            BAT_NOBAT: begin
              if (c < 50) bat_lvl = 3'b111;
              if (strictly_in(c, 50, 150)) bat_lvl = 3'b000;
              if (strictly_in(c, 150, 200)) bat_lvl = 3'b111;
              if (strictly_in(c, 200, 1000)) bat_lvl = 3'b000;
              if (c > 1000) bat_cnt = '0;
            end
            BAT_CAL_RUN: begin
              if (strictly_in(c, 0, 50)) volt_lvl = 7'h20;
              if (strictly_in(c, 50, 100)) volt_lvl = 7'h10;
              if (strictly_in(c, 100, 150)) volt_lvl = 7'h08;
              if (strictly_in(c, 150, 200)) volt_lvl = 7'h04;
              if (strictly_in(c, 200, 250)) volt_lvl = 7'h02;
              if (strictly_in(c, 250, 300)) volt_lvl = 7'h01;
              if (strictly_in(c, 300, 350)) volt_lvl = 7'h40;
              if (c > 400) bat_cnt = '0;
            end
            default: begin
              if (strictly_in(c, 0, 50)) volt_lvl = 7'h7F;
              if (strictly_in(c, 50, 1000)) volt_lvl = 7'h00;
              if (c > 1000) bat_cnt = '0;
            end
          endcase
        end
        default: ;
      endcase

      case (ext_mode)
        EXT_OFF: begin
          ext_lvl = 1'b0;
          ext_cnt = '0;
        end
        EXT_ON: begin
          ext_lvl = 1'b1;
          ext_cnt = '0;
        end
        EXT_BLINK: begin
          ext_cnt = ext_cnt + 1'b1;
          ext_lvl = (ext_cnt < 500) ? 1'b0 : 1'b1;
          if (ext_cnt > 1000) ext_cnt = '0;
        end
        default: ;
      endcase
    endfunction

    function void note_tick(input bit tick);
      levels_t l;
      if (tick) advance_patterns();
      l.buz  = buz_lvl;
      l.bat  = bat_lvl;
      l.volt = volt_lvl;
      l.ext  = ext_lvl;
      expected_levels.push_back(l);
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= 20) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_levels(input logic [OUT_TDATA_W-1:0] tdata);
      levels_t got;
      levels_t want;
      got = levels_t'(tdata[OUT_W-1:0]);
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected item %h", tdata));
        return;
      end
      want = expected_levels.pop_front();
      if (got.buz !== want.buz)
        report_mismatch($sformatf("buzzer_on %b, want %b", got.buz, want.buz));
      if (got.bat !== want.bat)
        report_mismatch($sformatf("battery_leds %b, want %b", got.bat, want.bat));
      if (got.volt !== want.volt)
        report_mismatch($sformatf("voltage_leds %b, want %b", got.volt, want.volt));
      if (got.ext !== want.ext)
        report_mismatch($sformatf("external_led %b, want %b", got.ext, want.ext));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pattern_scoreboard sb = new();
  bit src_quiet = 1'b0;
  bit snk_quiet = 1'b0;
  bit hold_now  = 1'b0;

  indicator_pattern_generator_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  task automatic send_item(input bit tick);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, tick};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(tick);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mode(idx, d);
  endtask

  task automatic write_modes(input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] bt,
                             input logic [CFG_DATA_W-1:0] e, input bit spare);
    put_reg(CFG_BUZZER, b);
    put_reg(CFG_BATTERY, bt);
    put_reg(CFG_EXTERNAL, e);
    if (spare) put_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 15)));
    cfg_valid <= 1'b0;
  endtask

  // sink: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_levels(m_axis_tdata);
      if (hold_now) begin
        stall    = HOLD_CYCLES;
        hold_now = 1'b0;
      end else if (snk_quiet) begin
        stall = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] b;
    logic [CFG_DATA_W-1:0] bt;
    logic [CFG_DATA_W-1:0] e;
    bit long_phase;
    int len;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset levels, with and without ticks
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    drain();
    // steady and solid levels, then all-ones mode data (unused modes hold)
    write_modes(BUZ_STEADY, BAT_SOLID3, EXT_ON, 1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    drain();
    write_modes(4'hF, 4'hF, 4'hF, 1'b1);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    drain();
    write_modes(BUZ_OFF, BAT_SOLID1, EXT_OFF, 1'b0);
    send_item(1'b1);
    send_item(1'b1);
    drain();
    write_modes(BUZ_OFF, BAT_SOLID2, EXT_BLINK, 1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    drain();

    // mode phases; counters carry across phases so edges land at random counts
    for (int p = 0; p < 16; p++) begin
      b  = (p < 6) ? CFG_DATA_W'(p) : CFG_DATA_W'($urandom_range(0, 15));
      bt = (p < 11) ? CFG_DATA_W'(p) : CFG_DATA_W'($urandom_range(0, 15));
      e  = (p < 4) ? CFG_DATA_W'(p) : CFG_DATA_W'($urandom_range(0, 15));
      write_modes(b, bt, e, $urandom_range(0, 3) == 0);
      long_phase = (b[BUZ_MODE_W-1:0] == BUZ_SLOW) || (b[BUZ_MODE_W-1:0] == BUZ_SOS) ||
                   (bt == BAT_BLINK) || (bt == BAT_FILL2) || (bt == BAT_FILL3) ||
                   (bt == BAT_SHORT) || (bt == BAT_NOBAT) || (bt == BAT_CAL_FAIL);
      len = long_phase ? $urandom_range(70, 110) : $urandom_range(40, 70);
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        src_quiet = 1'b1;
        snk_quiet = 1'b0;
        hold_now  = 1'b1;
      end
      for (int n = 0; n < len; n++) send_item($urandom_range(0, 11) != 0);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_levels.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

### filelist.f
rtl/ipg_pkg.sv
rtl/ipg_buzzer.sv
rtl/ipg_battery.sv
rtl/ipg_external.sv
rtl/indicator_pattern_generator_unit.sv
dv/tb.sv
